// ===== rtl/mandelbrot_pixel_colorizer_top_assert.svh =====
// Assertion macros for the Mandelbrot pixel colorizer.
// Included by mandelbrot_pixel_colorizer_top.sv; no other dependencies.
`ifndef MANDELBROT_PIXEL_COLORIZER_TOP_ASSERT_SVH
`define MANDELBROT_PIXEL_COLORIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true out of reset
`define MPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/mpc_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot pixel colorizer.
// No dependencies; used by mandelbrot_pixel_colorizer_top.sv.
package mpc_pkg;

    // parameter defaults
    localparam int SCREEN_WIDTH_DEF  = 1920;
    localparam int SCREEN_HEIGHT_DEF = 1080;
    localparam int ITER_LIMIT_DEF    = 512;

    // field and bus widths
    localparam int PIX_W        = 11;
    localparam int COORD_W      = 32;
    localparam int STEP_W       = 31;
    localparam int COLOR_W      = 8;
    localparam int COUNT_W      = 10;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int OFF_W        = 14;   // 2*pixel - screen size, signed
    localparam int PROD_W       = 64;
    localparam int MAP_SUM_W    = 48;
    localparam int FRAC_BITS    = 28;

    // |z|^2 escape bound: 4.0 in Q4.28
    localparam int unsigned ESCAPE_BOUND = 32'h4000_0000;

    // config register reset values
    localparam logic signed [COORD_W-1:0] CENTER_X_RST = '0;
    localparam logic signed [COORD_W-1:0] CENTER_Y_RST = '0;
    localparam logic [STEP_W-1:0]         STEP_X_RST   = 31'd279620;
    localparam logic [STEP_W-1:0]         STEP_Y_RST   = 31'd497102;

    // config register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X = 4'd0,
        CFG_CENTER_Y = 4'd1,
        CFG_STEP_X   = 4'd2,
        CFG_STEP_Y   = 4'd3
    } cfg_index_t;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MAP   = 8'b0000_0010,
        ST_SETUP = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_UPD   = 8'b0001_0000,
        ST_COLOR = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // clamp a wide signed value into signed 32 bits
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [MAP_SUM_W-1:0] v);
        if (v[MAP_SUM_W-1:COORD_W-1] == {(MAP_SUM_W-COORD_W+1){v[MAP_SUM_W-1]}})
            return $signed(v[COORD_W-1:0]);
        else if (v[MAP_SUM_W-1])
            return $signed({1'b1, {(COORD_W-1){1'b0}}});
        else
            return $signed({1'b0, {(COORD_W-1){1'b1}}});
    endfunction

endpackage

// ===== rtl/mandelbrot_pixel_colorizer_top.sv =====
// Mandelbrot escape-time pixel colorizer: pixel in, escape count and RGB out.
// Depends on mpc_pkg.sv and mandelbrot_pixel_colorizer_top_assert.svh.
//
// One pixel at a time. A pixel beat maps the pixel to c = (pixel - size/2) * step
// + center in Q4.28, iterates z = z*z + c until |z|^2 >= 4 or ITER_LIMIT steps,
// and returns the count and a six-sector HSV hue (black if it never escaped).
// A three-lane 32x32 multiply unit is reused for the mapping and for every
// iteration; each iteration is a multiply state followed by an add/saturate and
// escape-test state. The finished result waits while an earlier beat still
// sits unread in the output register. The hue fraction is divided by the limit
// with one constant reciprocal multiply. s_axis_tready is high only while the
// sequencer is idle, so the next pixel can be taken in the cycle after the
// result is loaded; the result sits in an output register, so a new pixel is
// taken while an earlier result still waits. Config writes (cfg_ready is always
// high) are to be made while no pixel is in flight.
`include "mandelbrot_pixel_colorizer_top_assert.svh"

module mandelbrot_pixel_colorizer_top #(
    parameter int SCREEN_WIDTH  = mpc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpc_pkg::SCREEN_HEIGHT_DEF,
    parameter int ITER_LIMIT    = mpc_pkg::ITER_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pixel_x[10:0], pixel_y[21:11]
    // result output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // red[7:0], green[15:8],
                                                               // blue[23:16], escape_count[33:24]
    // config write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(ITER_LIMIT + 1);
    localparam int SIX_W = CNT_W + 3;
    localparam int NUM_W = CNT_W + 8;
    localparam int PIX_W = mpc_pkg::PIX_W;
    localparam int OFF_W = mpc_pkg::OFF_W;
    localparam int PW    = mpc_pkg::PROD_W;
    localparam int MW    = mpc_pkg::MAP_SUM_W;
    localparam int CW    = mpc_pkg::COORD_W;
    localparam int FB    = mpc_pkg::FRAC_BITS;
    localparam int SQ_W  = PW - FB;         // xx, yy after the Q4.28 shift
    localparam int XY_W  = PW - FB + 1;     // 2*x*y after the shift
    localparam int RCP_S = NUM_W + CNT_W;   // reciprocal scale, exact for any numerator
    localparam int RP_W  = NUM_W + RCP_S;   // reciprocal product width

    localparam logic signed [OFF_W-1:0] SCR_W_S  = OFF_W'(SCREEN_WIDTH);
    localparam logic signed [OFF_W-1:0] SCR_H_S  = OFF_W'(SCREEN_HEIGHT);
    localparam logic [CNT_W-1:0]        LIMIT_C  = CNT_W'(ITER_LIMIT);
    localparam logic [SIX_W-1:0]        T1       = SIX_W'(ITER_LIMIT);
    localparam logic [SIX_W-1:0]        T2       = SIX_W'(2 * ITER_LIMIT);
    localparam logic [SIX_W-1:0]        T3       = SIX_W'(3 * ITER_LIMIT);
    localparam logic [SIX_W-1:0]        T4       = SIX_W'(4 * ITER_LIMIT);
    localparam logic [SIX_W-1:0]        T5       = SIX_W'(5 * ITER_LIMIT);
    localparam logic [NUM_W-1:0]        NUM_MAX  = NUM_W'(255 * ITER_LIMIT);
    localparam logic [RCP_S-1:0]        RCP_M    =
        RCP_S'(((64'd1 << RCP_S) + 64'(ITER_LIMIT) - 64'd1) / 64'(ITER_LIMIT));
    localparam logic [SQ_W:0]           BOUND_C  = (SQ_W + 1)'(mpc_pkg::ESCAPE_BOUND);
    localparam logic [7:0]              FULL     = 8'hFF;

    // hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    mpc_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0]             center_x_reg, center_y_reg;
    logic [mpc_pkg::STEP_W-1:0]       step_x_reg, step_y_reg;
    logic [PIX_W-1:0]                 pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic signed [PW-1:0]             p_xx_reg, p_xx_next, p_yy_reg, p_yy_next;
    logic signed [PW-1:0]             p_xy_reg, p_xy_next;
    logic signed [CW-1:0]             x0_reg, x0_next, y0_reg, y0_next;
    logic signed [CW-1:0]             x_reg, x_next, y_reg, y_next;
    logic [CNT_W-1:0]                 n_reg, n_next;
    sector_t                          sector_reg, sector_next;
    logic [NUM_W-1:0]                 num_reg, num_next;
    logic [7:0]                       quot_reg, quot_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [mpc_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                             out_load;

    // shared multiply unit operands and products
    logic signed [OFF_W-1:0]          off_x, off_y;
    logic signed [CW-1:0]             op_a0, op_a1, op_b0, op_b1;
    logic signed [PW-1:0]             mul_a, mul_b, mul_c;

    // iteration update and mapping sums
    logic signed [SQ_W-1:0]           xx, yy;
    logic signed [XY_W-1:0]           xy2;
    logic [SQ_W:0]                    esc_sum;
    logic signed [MW-1:0]             map_x_sum, map_y_sum, nx_sum, ny_sum;

    // coloring
    logic [SIX_W-1:0]                 six, base, rem6, ad, frac_m;
    sector_t                          sec;
    logic [NUM_W-1:0]                 num;
    logic [RP_W-1:0]                  recip_prod;
    logic [7:0]                       red, green, blue;

    assign s_axis_tready = (state_reg == mpc_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = out_data_reg;

    // mapping offsets: 2*pixel - screen size
    assign off_x = $signed({2'b00, pix_x_reg, 1'b0}) - SCR_W_S;
    assign off_y = $signed({2'b00, pix_y_reg, 1'b0}) - SCR_H_S;

    // lane operand select: mapping uses lanes a and b, iteration all three
    always_comb
    begin
        if (state_reg == mpc_pkg::ST_MAP)
        begin
            op_a0 = CW'(off_x);
            op_a1 = $signed({1'b0, step_x_reg});
            op_b0 = CW'(off_y);
            op_b1 = $signed({1'b0, step_y_reg});
        end
        else
        begin
            op_a0 = x_reg;
            op_a1 = x_reg;
            op_b0 = y_reg;
            op_b1 = y_reg;
        end
    end

    assign mul_a = PW'(op_a0) * PW'(op_a1);
    assign mul_b = PW'(op_b0) * PW'(op_b1);
    assign mul_c = PW'(x_reg) * PW'(y_reg);

    // mapping: floor(product / 2) + center, saturated
    assign map_x_sum = MW'(p_xx_reg >>> 1) + MW'(center_x_reg);
    assign map_y_sum = MW'(p_yy_reg >>> 1) + MW'(center_y_reg);

    // iteration: Q4.28 squares and doubled cross term
    assign xx      = $signed(p_xx_reg[PW-1:FB]);
    assign yy      = $signed(p_yy_reg[PW-1:FB]);
    assign xy2     = $signed(p_xy_reg[PW-1:FB-1]);
    assign esc_sum = {1'b0, xx[SQ_W-1:0]} + {1'b0, yy[SQ_W-1:0]};
    assign nx_sum  = MW'(xx) - MW'(yy) + MW'(x0_reg);
    assign ny_sum  = MW'(xy2) + MW'(y0_reg);

    // hue sector and distance from sector pair center
    always_comb
    begin
        six = (SIX_W'(n_reg) << 2) + (SIX_W'(n_reg) << 1);
        if (six >= T5)
            sec = SEC_MAG_RED;
        else if (six >= T4)
            sec = SEC_BLU_MAG;
        else if (six >= T3)
            sec = SEC_CYN_BLU;
        else if (six >= T2)
            sec = SEC_GRN_CYN;
        else if (six >= T1)
            sec = SEC_YEL_GRN;
        else
            sec = SEC_RED_YEL;
        case (sec)
            SEC_RED_YEL, SEC_YEL_GRN: base = '0;
            SEC_GRN_CYN, SEC_CYN_BLU: base = T2;
            default:                  base = T4;
        endcase
        rem6   = six - base;
        ad     = (rem6 >= T1) ? (rem6 - T1) : (T1 - rem6);
        frac_m = T1 - ad;
        num    = (NUM_W'(frac_m) << 8) - NUM_W'(frac_m);
    end

    // divide by the limit: multiply by the scaled reciprocal, keep the top bits
    assign recip_prod = RP_W'(num_reg) * RP_W'(RCP_M);

    // output color from sector and fraction
    always_comb
    begin
        red   = '0;
        green = '0;
        blue  = '0;
        if (n_reg < LIMIT_C)
        begin
            case (sector_reg)
                SEC_RED_YEL: begin red = FULL;     green = quot_reg; end
                SEC_YEL_GRN: begin red = quot_reg; green = FULL;     end
                SEC_GRN_CYN: begin green = FULL;   blue = quot_reg;  end
                SEC_CYN_BLU: begin green = quot_reg; blue = FULL;    end
                SEC_BLU_MAG: begin red = quot_reg; blue = FULL;      end
                default:     begin red = FULL;     blue = quot_reg;  end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        p_xx_next     = p_xx_reg;
        p_yy_next     = p_yy_reg;
        p_xy_next     = p_xy_reg;
        x0_next       = x0_reg;
        y0_next       = y0_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        n_next        = n_reg;
        sector_next   = sector_reg;
        num_next      = num_reg;
        quot_next     = quot_reg;
        out_load      = 1'b0;
        case (state_reg)
            mpc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pix_x_next = s_axis_tdata[PIX_W-1:0];
                    pix_y_next = s_axis_tdata[2*PIX_W-1:PIX_W];
                    state_next = mpc_pkg::ST_MAP;
                end
            end
            mpc_pkg::ST_MAP:
            begin
                p_xx_next  = mul_a;
                p_yy_next  = mul_b;
                state_next = mpc_pkg::ST_SETUP;
            end
            mpc_pkg::ST_SETUP:
            begin
                x0_next    = mpc_pkg::sat32(map_x_sum);
                y0_next    = mpc_pkg::sat32(map_y_sum);
                x_next     = '0;
                y_next     = '0;
                n_next     = '0;
                state_next = mpc_pkg::ST_MUL;
            end
            mpc_pkg::ST_MUL:
            begin
                p_xx_next  = mul_a;
                p_yy_next  = mul_b;
                p_xy_next  = mul_c;
                state_next = mpc_pkg::ST_UPD;
            end
            mpc_pkg::ST_UPD:
            begin
                if (n_reg >= LIMIT_C)
                    state_next = mpc_pkg::ST_DONE;
                else if (esc_sum >= BOUND_C)
                    state_next = mpc_pkg::ST_COLOR;
                else
                begin
                    x_next     = mpc_pkg::sat32(nx_sum);
                    y_next     = mpc_pkg::sat32(ny_sum);
                    n_next     = n_reg + 1'b1;
                    state_next = mpc_pkg::ST_MUL;
                end
            end
            mpc_pkg::ST_COLOR:
            begin
                sector_next = sec;
                num_next    = num;
                state_next  = mpc_pkg::ST_DIV;
            end
            mpc_pkg::ST_DIV:
            begin
                quot_next  = recip_prod[RCP_S +: 8];
                state_next = mpc_pkg::ST_DONE;
            end
            mpc_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mpc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mpc_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_comb
    begin
        out_data_next = out_data_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            out_data_next = {6'b0, mpc_pkg::COUNT_W'(n_reg), blue, green, red};
        end
        else if (m_axis_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // control state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mpc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            center_x_reg <= mpc_pkg::CENTER_X_RST;
            center_y_reg <= mpc_pkg::CENTER_Y_RST;
            step_x_reg   <= mpc_pkg::STEP_X_RST;
            step_y_reg   <= mpc_pkg::STEP_Y_RST;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (mpc_pkg::cfg_index_t'(cfg_index))
                    mpc_pkg::CFG_CENTER_X: center_x_reg <= $signed(cfg_data);
                    mpc_pkg::CFG_CENTER_Y: center_y_reg <= $signed(cfg_data);
                    mpc_pkg::CFG_STEP_X:   step_x_reg   <= cfg_data[mpc_pkg::STEP_W-1:0];
                    mpc_pkg::CFG_STEP_Y:   step_y_reg   <= cfg_data[mpc_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        p_xx_reg     <= p_xx_next;
        p_yy_reg     <= p_yy_next;
        p_xy_reg     <= p_xy_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        n_reg        <= n_next;
        sector_reg   <= sector_next;
        num_reg      <= num_next;
        quot_reg     <= quot_next;
        out_data_reg <= out_data_next;
    end

    // checks
    `MPC_ASSERT(a_accept_to_map, clk, rst_n, s_axis_tvalid && s_axis_tready |=> state_reg == mpc_pkg::ST_MAP, "accepted pixel did not start mapping")
    `MPC_ASSERT(a_iter_bound, clk, rst_n, state_reg == mpc_pkg::ST_UPD |-> n_reg <= LIMIT_C, "iteration count past limit")
    `MPC_ASSERT_NEVER(a_out_overrun, clk, rst_n, out_load && m_axis_tvalid && !m_axis_tready, "result overwrote a pending beat")
    `MPC_ASSERT(a_num_range, clk, rst_n, state_reg == mpc_pkg::ST_DIV |-> num_reg <= NUM_MAX, "hue numerator out of range")

endmodule

// ===== sim/mandelbrot_pixel_colorizer_top_tb.sv =====
// Self-checking testbench for mandelbrot_pixel_colorizer_top: escape count and HSV hue per pixel.
// Depends on mpc_pkg.sv and the top level; an internal predictor works out the expected colors.
`timescale 1ns / 1ps

module mandelbrot_pixel_colorizer_top_tb;

    localparam int          CLK_HALF       = 10;
    localparam int          RESET_CYCLES   = 9;
    localparam int unsigned CYCLE_LIMIT    = 6_000_000;
    localparam int          RANDOM_PIXELS  = 1130;
    localparam int          CALM_TAIL      = 120;
    localparam int          SETTLE_CYCLES  = 24;
    localparam logic [mpc_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
    localparam logic [mpc_pkg::COLOR_W-1:0]     COLOR_FULL       = 8'hFF;
    localparam longint      Q428_ONE       = 64'sd268435456;

    // hue sectors, red through magenta and back
    typedef enum int {
        HUE_RED_YELLOW,
        HUE_YELLOW_GREEN,
        HUE_GREEN_CYAN,
        HUE_CYAN_BLUE,
        HUE_BLUE_MAGENTA,
        HUE_MAGENTA_RED
    } hue_sector_t;

    typedef struct packed {
        logic [mpc_pkg::PIX_W-1:0] py;
        logic [mpc_pkg::PIX_W-1:0] px;
    } pixel_coord_t;

    typedef struct packed {
        logic [mpc_pkg::COLOR_W-1:0] red;
        logic [mpc_pkg::COLOR_W-1:0] green;
        logic [mpc_pkg::COLOR_W-1:0] blue;
        logic [mpc_pkg::COUNT_W-1:0] count;
    } pixel_color_t;

    typedef struct {
        pixel_coord_t coord;
        pixel_color_t color;
    } color_expect_t;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [mpc_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [mpc_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    // shadow copy of the view registers
    logic signed [mpc_pkg::COORD_W-1:0] view_center_x = mpc_pkg::CENTER_X_RST;
    logic signed [mpc_pkg::COORD_W-1:0] view_center_y = mpc_pkg::CENTER_Y_RST;
    logic [mpc_pkg::STEP_W-1:0]         view_step_x   = mpc_pkg::STEP_X_RST;
    logic [mpc_pkg::STEP_W-1:0]         view_step_y   = mpc_pkg::STEP_Y_RST;

    pixel_coord_t  pending_pixels[$];
    color_expect_t expected_colors[$];
    int            pixels_queued  = 0;
    int            results_seen   = 0;
    int            mismatch_count = 0;
    int            send_gap       = 0;
    int            stall_left     = 0;
    int            calm_left      = 0;
    bit            idle_enable    = 1'b1;
    int unsigned   cycle_count    = 0;

    mandelbrot_pixel_colorizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pixel_x[10:0], pixel_y[21:11]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // red[7:0], green[15:8], blue[23:16], count[33:24]
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // clamp into signed 32 bits
    function automatic longint clamp_q428(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // pixel offset from screen middle times step, plus center
    function automatic longint map_to_plane(input longint pix, input longint size,
                                            input longint step, input longint ctr);
        longint off;
        off = 2 * pix - size;
        return clamp_q428(((off * step) >>> 1) + ctr);
    endfunction

    // escape-time iteration and six-sector hue for one pixel
    function automatic pixel_color_t colorize_pixel(input pixel_coord_t coord);
        longint      c_re, c_im, z_re, z_im, re2, im2, nxt_re;
        longint      six, hue_dist, frac;
        int          iters;
        bit          running;
        hue_sector_t sector;
        pixel_color_t color;
        c_re = map_to_plane(longint'(coord.px), mpc_pkg::SCREEN_WIDTH_DEF,
                            longint'(view_step_x), longint'(view_center_x));
        c_im = map_to_plane(longint'(coord.py), mpc_pkg::SCREEN_HEIGHT_DEF,
                            longint'(view_step_y), longint'(view_center_y));
        z_re    = 0;
        z_im    = 0;
        iters   = 0;
        running = 1'b1;
        while (running)
        begin
            re2 = (z_re * z_re) >>> mpc_pkg::FRAC_BITS;
            im2 = (z_im * z_im) >>> mpc_pkg::FRAC_BITS;
            if (re2 + im2 >= longint'(mpc_pkg::ESCAPE_BOUND) ||
                iters >= mpc_pkg::ITER_LIMIT_DEF)
                running = 1'b0;
            else
            begin
                nxt_re = clamp_q428(re2 - im2 + c_re);
                z_im   = clamp_q428(((z_re * z_im) >>> (mpc_pkg::FRAC_BITS - 1)) + c_im);
                z_re   = nxt_re;
                iters++;
            end
        end

        color       = '0;
        color.count = iters[mpc_pkg::COUNT_W-1:0];
        // never escaped: stays black
        if (iters < mpc_pkg::ITER_LIMIT_DEF)
        begin
            six      = 6 * iters;
            hue_dist = (six % (2 * mpc_pkg::ITER_LIMIT_DEF)) - mpc_pkg::ITER_LIMIT_DEF;
            if (hue_dist < 0)
                hue_dist = -hue_dist;
            frac   = (longint'(COLOR_FULL) * (mpc_pkg::ITER_LIMIT_DEF - hue_dist))
                     / mpc_pkg::ITER_LIMIT_DEF;
            sector = hue_sector_t'(six / mpc_pkg::ITER_LIMIT_DEF);
            case (sector)
                HUE_RED_YELLOW:   begin color.red = COLOR_FULL; color.green = frac[7:0]; end
                HUE_YELLOW_GREEN: begin color.red = frac[7:0]; color.green = COLOR_FULL; end
                HUE_GREEN_CYAN:   begin color.green = COLOR_FULL; color.blue = frac[7:0]; end
                HUE_CYAN_BLUE:    begin color.green = frac[7:0]; color.blue = COLOR_FULL; end
                HUE_BLUE_MAGENTA: begin color.red = frac[7:0]; color.blue = COLOR_FULL; end
                default:          begin color.red = COLOR_FULL; color.blue = frac[7:0]; end
            endcase
        end
        return color;
    endfunction

    function automatic void check_field(input string name, input int want, input int got,
                                        input pixel_coord_t coord);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: pixel (%0d,%0d) %s expected %0d, actual %0d",
                     $time, coord.px, coord.py, name, want, got);
        end
    endfunction

    // pixel driver: pulls from the pending queue, predicts on every accepted beat
    always @(posedge clk)
    begin : pixel_driver
        pixel_coord_t  nxt;
        color_expect_t entry;
        if (s_axis_tvalid && s_axis_tready)
        begin
            entry.coord.px = s_axis_tdata[mpc_pkg::PIX_W-1:0];
            entry.coord.py = s_axis_tdata[2*mpc_pkg::PIX_W-1:mpc_pkg::PIX_W];
            entry.color    = colorize_pixel(entry.coord);
            expected_colors.push_back(entry);
        end
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                nxt = pending_pixels.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(mpc_pkg::IN_TDATA_W-2*mpc_pkg::PIX_W){1'b0}},
                                  nxt.py, nxt.px};
                if (idle_enable && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 12);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin : result_monitor
        color_expect_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_colors.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with nothing pending, expected none, actual 0x%h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_colors.pop_front();
                check_field("red", want.color.red,
                            m_axis_tdata[mpc_pkg::COLOR_W-1:0], want.coord);
                check_field("green", want.color.green,
                            m_axis_tdata[2*mpc_pkg::COLOR_W-1:mpc_pkg::COLOR_W], want.coord);
                check_field("blue", want.color.blue,
                            m_axis_tdata[3*mpc_pkg::COLOR_W-1:2*mpc_pkg::COLOR_W],
                            want.coord);
                check_field("escape_count", want.color.count,
                            m_axis_tdata[3*mpc_pkg::COLOR_W+mpc_pkg::COUNT_W-1:
                                         3*mpc_pkg::COLOR_W], want.coord);
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (calm_left > 0)
            calm_left--;
        else if (idle_enable && rst_n)
        begin
            case ($urandom_range(0, 3))
                0:       stall_left = $urandom_range(1, 12);
                1:       calm_left  = $urandom_range(10, 100);
                default: ;
            endcase
        end
        m_axis_tready <= rst_n && (stall_left == 0);
    end

    // run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pixels_queued - results_seen);
            $display("Mismatches found");
            $finish;
        end
    end

    // one register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [mpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mpc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mpc_pkg::CFG_CENTER_X: view_center_x = val;
            mpc_pkg::CFG_CENTER_Y: view_center_y = val;
            mpc_pkg::CFG_STEP_X:   view_step_x   = val[mpc_pkg::STEP_W-1:0];
            mpc_pkg::CFG_STEP_Y:   view_step_y   = val[mpc_pkg::STEP_W-1:0];
            default:               ;
        endcase
    endtask

    task automatic load_view(input logic [mpc_pkg::CFG_DATA_W-1:0] cx,
                             input logic [mpc_pkg::CFG_DATA_W-1:0] cy,
                             input logic [mpc_pkg::CFG_DATA_W-1:0] sx,
                             input logic [mpc_pkg::CFG_DATA_W-1:0] sy,
                             input bit stray);
        write_reg(mpc_pkg::CFG_CENTER_X, cx);
        write_reg(mpc_pkg::CFG_CENTER_Y, cy);
        write_reg(mpc_pkg::CFG_STEP_X, sx);
        write_reg(mpc_pkg::CFG_STEP_Y, sy);
        // unmapped index must leave the view alone
        if (stray)
            write_reg(mpc_pkg::CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED,
                                                           {mpc_pkg::CFG_INDEX_W{1'b1}})),
                      $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input int px, input int py);
        pixel_coord_t coord;
        coord.px = px[mpc_pkg::PIX_W-1:0];
        coord.py = py[mpc_pkg::PIX_W-1:0];
        pending_pixels.push_back(coord);
        pixels_queued++;
    endtask

    // mostly on-screen pixels, some anywhere in the 11-bit range
    task automatic queue_random_pixels(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 6) == 0)
                queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
            else
                queue_pixel($urandom_range(0, mpc_pkg::SCREEN_WIDTH_DEF - 1),
                            $urandom_range(0, mpc_pkg::SCREEN_HEIGHT_DEF - 1));
        end
    endtask

    task automatic wait_for_drain();
        do @(posedge clk); while (results_seen < pixels_queued);
    endtask

    // points on or near the set boundary, where escape counts spread widely
    function automatic void pick_boundary_point(output longint re, output longint im);
        real pr, pi;
        case ($urandom_range(0, 5))
            0:       begin pr = -0.75;   pi = 0.1;    end
            1:       begin pr = -0.7436; pi = 0.1318; end
            2:       begin pr = -1.25;   pi = 0.0;    end
            3:       begin pr = 0.285;   pi = 0.01;   end
            4:       begin pr = -0.1011; pi = 0.9563; end
            default: begin pr = -1.7685; pi = 0.0;    end
        endcase
        re = $rtoi(pr * 268435456.0) + int'($urandom_range(0, 8191)) - 4096;
        im = $rtoi(pi * 268435456.0) + int'($urandom_range(0, 8191)) - 4096;
    endfunction

    function automatic logic [mpc_pkg::CFG_DATA_W-1:0] pick_extreme_center();
        case ($urandom_range(0, 2))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [mpc_pkg::CFG_DATA_W-1:0] pick_extreme_step();
        case ($urandom_range(0, 2))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            default: return {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
        endcase
    endfunction

    // stimulus sequence
    initial
    begin : stimulus
        longint cre, cim;
        int     random_sent;
        int     burst;
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: center, corners, off-screen, in-set and quick escapes
        queue_pixel(960, 540);
        queue_pixel(0, 0);
        queue_pixel(1919, 1079);
        queue_pixel(0, 1079);
        queue_pixel(1919, 0);
        queue_pixel(2047, 2047);
        queue_pixel(2047, 0);
        queue_pixel(0, 2047);
        queue_pixel(0, 540);
        queue_pixel(700, 540);
        queue_pixel(1919, 540);
        queue_pixel(1024, 1024);
        wait_for_drain();

        // saturating view: widest steps and centers at the rails
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_pixel(0, 0);
        queue_pixel(1919, 1079);
        queue_pixel(960, 540);
        queue_pixel(2047, 2047);
        wait_for_drain();

        // zero step: every pixel lands on the center, plus a stray index write
        load_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_pixel(1919, 1079);
        wait_for_drain();
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1);
        queue_pixel(5, 7);
        wait_for_drain();

        // random views, each followed by a burst of pixels
        while (random_sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    pick_boundary_point(cre, cim);
                    load_view(cre[31:0], cim[31:0],
                              {$urandom_range(0, 1) == 1, 31'($urandom_range(400, 40000))},
                              {$urandom_range(0, 1) == 1, 31'($urandom_range(400, 40000))},
                              $urandom_range(0, 2) == 0);
                end
                5, 6:
                begin
                    cre = int'($urandom_range(0, 2 * Q428_ONE)) - Q428_ONE;
                    cim = int'($urandom_range(0, 2 * Q428_ONE)) - Q428_ONE;
                    load_view(cre[31:0], cim[31:0],
                              32'($urandom_range(150000, 700000)),
                              32'($urandom_range(150000, 700000)),
                              $urandom_range(0, 2) == 0);
                end
                7:
                    load_view($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom_range(0, 1) == 1);
                8:
                    load_view(pick_extreme_center(), pick_extreme_center(),
                              pick_extreme_step(), pick_extreme_step(),
                              $urandom_range(0, 1) == 1);
                default:
                    load_view(mpc_pkg::CENTER_X_RST, mpc_pkg::CENTER_Y_RST,
                              32'(mpc_pkg::STEP_X_RST), 32'(mpc_pkg::STEP_Y_RST),
                              1'b0);
            endcase
            burst = $urandom_range(40, 110);
            if (RANDOM_PIXELS - random_sent <= CALM_TAIL)
            begin
                burst       = RANDOM_PIXELS - random_sent;
                idle_enable = 1'b0;
            end
            else if (burst > RANDOM_PIXELS - random_sent - CALM_TAIL)
                burst = RANDOM_PIXELS - random_sent - CALM_TAIL;
            queue_random_pixels(burst);
            random_sent += burst;
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
